// File: hdl/smbe_pkg.sv
// ----------------------------------------------------------------------------
// smbe_pkg
// Shared types, codes and helpers for the shadow memory bounds engine.
// ----------------------------------------------------------------------------
package smbe_pkg;

	typedef logic [7:0] shadow_t;

	typedef enum logic [1:0] {
		FN_WRITE  = 2'd0,
		FN_SIZE   = 2'd1,
		FN_BASE   = 2'd2,
		FN_ADJUST = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK,
		ST_DWALK,
		ST_UWALK,
		ST_ADJ,
		ST_GISSUE,
		ST_GCHK,
		ST_SISSUE,
		ST_SCHK,
		ST_RESTART
	} state_t;

	localparam shadow_t     POISON_INIT   = 8'hFE;
	localparam logic [12:0] MAX_WALK_RST  = 13'd4096;
	localparam logic [15:0] REDZONE_LIMIT = 16'd16;
	localparam logic [7:0]  GRAN_BYTES    = 8'd8;

	// Accessible bytes of one granule: zero means the whole granule.
	function automatic logic [6:0] gran_size(input shadow_t b);
		gran_size = (b == 8'd0) ? 7'd8 : b[6:0];
	endfunction

endpackage

// File: hdl/shadow_memory_bounds_engine.sv
// ----------------------------------------------------------------------------
// shadow_memory_bounds_engine
// Shadow store with bounds queries, shadow writes and redzone adjustment.
// ----------------------------------------------------------------------------
// Issue a word with start while busy is low; the result appears on status,
// buffer_size and buffer_base for exactly one cycle marked by done and must
// be taken then, since the receiver cannot stall it. After reset the block
// runs a clearing pass that poisons every granule, one per cycle, while busy
// stays high; max_walk writes are taken at any time. A shadow write goes to
// the store as it is accepted. Queries walk the store through one read port
// at one granule per cycle: a size query walks the granules below addr in
// the buffer and then those above it, a base query only those below. An
// adjustment first walks up to the buffer end, then grows or shrinks through
// an issue and a check state per granule touched, and then runs a full size
// query. The single store read port and its registered read data set this
// pace.
// ----------------------------------------------------------------------------
module shadow_memory_bounds_engine #(
	parameter int GRANULES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [14:0]        addr,
	input  logic signed [7:0]  shadow_value,
	input  logic signed [15:0] adjustment,
	// result channel
	output logic               done,
	output logic               status,
	output logic [15:0]        buffer_size,
	output logic [14:0]        buffer_base,
	// configuration channel (max_walk)
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [12:0]        cfg_data
);

	// store index width, and a pointer width that also holds GRANULES itself
	localparam int GW = $clog2(GRANULES);
	localparam int AW = (GW + 1 > 12) ? GW + 1 : 12;
	localparam logic [AW-1:0] GR = AW'(GRANULES);

	smbe_pkg::state_t state_q, state_d;

	logic [12:0]       max_walk_q;
	logic [AW-1:0]     clr_q;
	logic [1:0]        func_q;
	logic [AW-1:0]     g_q;
	logic [2:0]        off_q;
	logic signed [15:0] adj_q;
	logic              phase_q;   // high for non-adjust commands, and once an adjustment's final size query runs
	logic [AW-1:0]     ptr_q;
	logic [12:0]       n_q;
	logic [19:0]       sum_q;
	logic [12:0]       down_q;
	smbe_pkg::shadow_t b_q;
	smbe_pkg::shadow_t lastv_q;
	smbe_pkg::shadow_t rz_q;
	logic [12:0]       cnt_q;
	logic [2:0]        rem_q;

	logic              done_q;
	logic              status_q;
	logic [15:0]       size_q;
	logic [14:0]       base_q;

	smbe_pkg::shadow_t rdata;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	smbe_pkg::shadow_t mem_wdata;
	logic [AW-1:0]     mem_raddr;

	logic              fin_fail, fin_write, fin_size, fin_base;

	// ------------------------------------------------------------------
	// Shared decode and arithmetic
	// ------------------------------------------------------------------
	logic          accept;
	logic [AW-1:0] g_in;
	logic          g_bad;
	logic          adj_bad;
	logic          rd_poison;
	logic          acc_ok;
	logic [13:0]   lim;
	logic [13:0]   n_inc;
	logic          lim_hit;
	logic          up_first;
	logic [AW-1:0] g_inc;
	logic          g_inc_edge;
	logic [AW-1:0] ptr_inc;
	logic [20:0]   tot;
	logic [15:0]   size_sat;

	assign accept     = start && !busy;
	assign g_in       = AW'(addr[14:3]);
	assign g_bad      = g_in >= GR;
	assign adj_bad    = (func == smbe_pkg::FN_ADJUST) &&
	                    (adjustment >= $signed(smbe_pkg::REDZONE_LIMIT));
	assign rd_poison  = rdata[7];
	assign acc_ok     = !rdata[7] && ((rdata == 8'd0) || ({5'd0, off_q} < rdata));
	assign lim        = (max_walk_q == 13'd0) ? 14'd1 : {1'b0, max_walk_q};
	assign n_inc      = {1'b0, n_q} + 14'd1;
	assign lim_hit    = n_inc >= lim;
	assign up_first   = (func_q == smbe_pkg::FN_ADJUST) && !phase_q;
	assign g_inc      = g_q + AW'(1);
	assign g_inc_edge = g_inc >= GR;
	assign ptr_inc    = ptr_q + AW'(1);

	assign tot = 21'(smbe_pkg::gran_size(b_q)) + 21'({down_q, 3'd0}) + 21'(sum_q);
	assign size_sat = (tot > 21'd65535) ? 16'hFFFF : tot[15:0];

	// adjustment arithmetic, used at the buffer end
	logic [7:0]  lsz;
	logic [7:0]  gsum;
	logic        grow_small, grow_eq;
	logic [7:0]  gd;
	logic [16:0] amount;
	logic        sh_lt, sh_eq;
	logic [16:0] sd;
	logic        adj_zero, adj_pos;
	smbe_pkg::shadow_t shrink_tail;

	assign lsz         = {1'b0, smbe_pkg::gran_size(lastv_q)};
	assign gsum        = lsz + {4'd0, adj_q[3:0]};
	assign grow_small  = (lsz > smbe_pkg::GRAN_BYTES) || (gsum < smbe_pkg::GRAN_BYTES);
	assign grow_eq     = gsum == smbe_pkg::GRAN_BYTES;
	assign gd          = gsum - smbe_pkg::GRAN_BYTES;
	assign amount      = 17'd0 - {adj_q[15], adj_q};
	assign sh_lt       = amount < {9'd0, lsz};
	assign sh_eq       = amount == {9'd0, lsz};
	assign sd          = amount - {9'd0, lsz};
	assign adj_zero    = adj_q == 16'sd0;
	assign adj_pos     = !adj_q[15] && !adj_zero;
	// a zero remainder leaves the new last granule full
	assign shrink_tail = (rem_q == 3'd0) ? 8'd0 : 8'(4'd8 - {1'b0, rem_q});

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smbe_pkg::ST_CLEAR: begin
				if (clr_q == GR - AW'(1)) state_d = smbe_pkg::ST_IDLE;
			end
			smbe_pkg::ST_IDLE: begin
				if (accept && !g_bad && !adj_bad && (func != smbe_pkg::FN_WRITE))
					state_d = smbe_pkg::ST_CHK;
			end
			smbe_pkg::ST_CHK: begin
				if (!acc_ok) state_d = smbe_pkg::ST_IDLE;
				else if (up_first) state_d = g_inc_edge ? smbe_pkg::ST_IDLE : smbe_pkg::ST_UWALK;
				else state_d = (g_q == '0) ? smbe_pkg::ST_IDLE : smbe_pkg::ST_DWALK;
			end
			smbe_pkg::ST_DWALK: begin
				if (rd_poison) begin
					if (func_q == smbe_pkg::FN_BASE || g_inc_edge) state_d = smbe_pkg::ST_IDLE;
					else state_d = smbe_pkg::ST_UWALK;
				end else if (lim_hit || ptr_q == AW'(1)) begin
					state_d = smbe_pkg::ST_IDLE;
				end
			end
			smbe_pkg::ST_UWALK: begin
				if (rd_poison) state_d = phase_q ? smbe_pkg::ST_IDLE : smbe_pkg::ST_ADJ;
				else if (lim_hit || ptr_inc >= GR) state_d = smbe_pkg::ST_IDLE;
			end
			smbe_pkg::ST_ADJ: begin
				if (adj_zero) state_d = smbe_pkg::ST_RESTART;
				else if (adj_pos) state_d = (grow_small || grow_eq) ?
					smbe_pkg::ST_RESTART : smbe_pkg::ST_GISSUE;
				else state_d = (sh_lt || sh_eq) ? smbe_pkg::ST_RESTART : smbe_pkg::ST_SISSUE;
			end
			smbe_pkg::ST_GISSUE: begin
				if (ptr_q >= GR || (cnt_q == 13'd0 && rem_q == 3'd0))
					state_d = smbe_pkg::ST_RESTART;
				else state_d = smbe_pkg::ST_GCHK;
			end
			smbe_pkg::ST_GCHK: begin
				if (rd_poison && cnt_q != 13'd0) state_d = smbe_pkg::ST_GISSUE;
				else state_d = smbe_pkg::ST_RESTART;
			end
			smbe_pkg::ST_SISSUE: begin
				state_d = (ptr_q == '0) ? smbe_pkg::ST_RESTART : smbe_pkg::ST_SCHK;
			end
			smbe_pkg::ST_SCHK: begin
				if (!rd_poison && cnt_q != 13'd0) state_d = smbe_pkg::ST_SISSUE;
				else state_d = smbe_pkg::ST_RESTART;
			end
			smbe_pkg::ST_RESTART: begin
				state_d = smbe_pkg::ST_CHK;
			end
			default: state_d = smbe_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs: store port control and completion events
	// ------------------------------------------------------------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = 8'd0;
		mem_raddr = ptr_q;
		fin_fail  = 1'b0;
		fin_write = 1'b0;
		fin_size  = 1'b0;
		fin_base  = 1'b0;
		unique case (state_q)
			smbe_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = smbe_pkg::POISON_INIT;
			end
			smbe_pkg::ST_IDLE: begin
				mem_raddr = g_in;
				mem_waddr = g_in;
				mem_wdata = shadow_value;
				if (accept) begin
					if (g_bad || adj_bad) begin
						fin_fail = 1'b1;
					end else if (func == smbe_pkg::FN_WRITE) begin
						mem_we    = 1'b1;
						fin_write = 1'b1;
					end
				end
			end
			smbe_pkg::ST_CHK: begin
				mem_raddr = up_first ? g_inc : g_q - AW'(1);
				if (!acc_ok) fin_fail = 1'b1;
				else if (up_first) fin_fail = g_inc_edge;
				else fin_fail = g_q == '0;
			end
			smbe_pkg::ST_DWALK: begin
				mem_raddr = rd_poison ? g_inc : ptr_q - AW'(2);
				if (rd_poison) begin
					if (func_q == smbe_pkg::FN_BASE) fin_base = 1'b1;
					else fin_fail = g_inc_edge;
				end else begin
					fin_fail = lim_hit || ptr_q == AW'(1);
				end
			end
			smbe_pkg::ST_UWALK: begin
				mem_raddr = ptr_inc;
				if (rd_poison) fin_size = phase_q;
				else fin_fail = lim_hit || ptr_inc >= GR;
			end
			smbe_pkg::ST_ADJ: begin
				// rewrite the last buffer granule
				mem_we = !adj_zero;
				if (adj_pos) mem_wdata = grow_small ? gsum : 8'd0;
				else mem_wdata = sh_lt ? lsz - amount[7:0] : rz_q;
			end
			smbe_pkg::ST_GISSUE: begin
				mem_raddr = ptr_q;
			end
			smbe_pkg::ST_GCHK: begin
				mem_we    = rd_poison;
				mem_wdata = (cnt_q != 13'd0) ? 8'd0 : {5'd0, rem_q};
			end
			smbe_pkg::ST_SISSUE: begin
				mem_raddr = ptr_q - AW'(1);
			end
			smbe_pkg::ST_SCHK: begin
				mem_we    = !rd_poison;
				mem_waddr = ptr_q - AW'(1);
				mem_wdata = (cnt_q != 13'd0) ? rz_q : shrink_tail;
			end
			smbe_pkg::ST_RESTART: begin
				mem_raddr = g_q;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= smbe_pkg::ST_CLEAR;
			clr_q      <= '0;
			max_walk_q <= smbe_pkg::MAX_WALK_RST;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == smbe_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_valid && cfg_ready) max_walk_q <= cfg_data;
			done_q <= fin_fail || fin_write || fin_size || fin_base;
		end
	end

	// ------------------------------------------------------------------
	// Walk datapath and result word
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (fin_fail || fin_write || fin_size || fin_base) begin
			status_q <= fin_fail;
			size_q   <= fin_size ? size_sat : 16'd0;
			base_q   <= fin_base ? {ptr_q[11:0], 3'd0} : 15'd0;
		end
		case (state_q)
			smbe_pkg::ST_IDLE: begin
				// latch the command word
				func_q  <= func;
				g_q     <= g_in;
				off_q   <= addr[2:0];
				adj_q   <= adjustment;
				phase_q <= func != smbe_pkg::FN_ADJUST;
			end
			smbe_pkg::ST_CHK: begin
				b_q     <= rdata;
				lastv_q <= rdata;
				n_q     <= 13'd0;
				sum_q   <= 20'd0;
				ptr_q   <= up_first ? g_inc : g_q;
			end
			smbe_pkg::ST_DWALK: begin
				if (rd_poison) begin
					// base found; turn around and walk up from g + 1
					down_q <= n_q;
					n_q    <= 13'd0;
					sum_q  <= 20'd0;
					ptr_q  <= g_inc;
				end else begin
					ptr_q <= ptr_q - AW'(1);
					n_q   <= n_inc[12:0];
				end
			end
			smbe_pkg::ST_UWALK: begin
				if (rd_poison) begin
					// hold the last buffer granule and the redzone byte behind it
					ptr_q <= ptr_q - AW'(1);
					rz_q  <= rdata;
				end else begin
					sum_q   <= sum_q + 20'(smbe_pkg::gran_size(rdata));
					lastv_q <= rdata;
					ptr_q   <= ptr_inc;
					n_q     <= n_inc[12:0];
				end
			end
			smbe_pkg::ST_ADJ: begin
				if (adj_pos) begin
					ptr_q <= ptr_inc;
					cnt_q <= 13'(gd[7:3]);
					rem_q <= gd[2:0];
				end else begin
					cnt_q <= sd[15:3];
					rem_q <= sd[2:0];
				end
			end
			smbe_pkg::ST_GCHK: begin
				if (rd_poison && cnt_q != 13'd0) begin
					cnt_q <= cnt_q - 13'd1;
					ptr_q <= ptr_inc;
				end
			end
			smbe_pkg::ST_SCHK: begin
				if (!rd_poison) begin
					ptr_q <= ptr_q - AW'(1);
					if (cnt_q != 13'd0) cnt_q <= cnt_q - 13'd1;
				end
			end
			smbe_pkg::ST_RESTART: begin
				phase_q <= 1'b1;
			end
			default: ;
		endcase
	end

	smbe_shadow_ram #(
		.DEPTH(GRANULES),
		.IW   (GW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr[GW-1:0]),
		.wdata(mem_wdata),
		.raddr(mem_raddr[GW-1:0]),
		.rdata(rdata)
	);

	assign busy        = state_q != smbe_pkg::ST_IDLE;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign buffer_size = size_q;
	assign buffer_base = base_q;

endmodule

// File: hdl/smbe_shadow_ram.sv
// ----------------------------------------------------------------------------
// smbe_shadow_ram
// Shadow byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smbe_shadow_ram #(
	parameter int DEPTH = 4096,
	parameter int IW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  smbe_pkg::shadow_t wdata,
	input  logic [IW-1:0]    raddr,
	output smbe_pkg::shadow_t rdata
);

	smbe_pkg::shadow_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
